### hw/rtl/priority_process_queues_core_assert.svh
// Assertion macros for the checker file.
`ifndef PRIORITY_PROCESS_QUEUES_CORE_ASSERT_SVH
`define PRIORITY_PROCESS_QUEUES_CORE_ASSERT_SVH

// Check cons in the same cycle whenever ante holds.
`define PPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante holds.
`define PPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ppq_pkg.sv
package ppq_pkg;

  // Field widths of one input word
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned QID_W  = 3;
  localparam int unsigned ENT_W  = 5;
  localparam int unsigned PRIO_W = 8;

  // Stream data widths, padded to whole bytes
  localparam int unsigned S_FIELDS_W = CMD_W + QID_W + ENT_W + PRIO_W;
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned M_FIELDS_W = 1 + ENT_W + ENT_W + 1;
  localparam int unsigned M_TDATA_W  = 16;
  localparam int unsigned M_PAD_W    = M_TDATA_W - M_FIELDS_W;

  // Bit positions of the result word
  localparam int unsigned OUT_STATUS  = 0;
  localparam int unsigned OUT_REMOVED = 1;
  localparam int unsigned OUT_HEAD    = OUT_REMOVED + ENT_W;
  localparam int unsigned OUT_EMPTY   = OUT_HEAD + ENT_W;

  // Status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Command codes; the remaining codes behave as a peek
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_POP    = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_PEEK   = 3'd4
  } cmd_e;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DISP = 5'b00010,
    ST_WALK = 5'b00100,
    ST_FIX  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

endpackage

### hw/rtl/priority_process_queues_core.sv
// Channel   | Dir | Bus                          | Fields (low bit up)
// s_axis    | in  | tvalid/tready/tdata[23:0]    | command, queue_id, entry_index,
//           |     |                              | priority_req
// m_axis    | out | tvalid/tready/tdata[15:0]    | status, removed_entry, head_entry,
//           |     |                              | queue_empty
//
// Peek and rejected commands go from dispatch straight to the result state; clear,
// insert, pop and remove walk the queue one link per cycle through the single
// read port of the link memory.
// s_axis_tready_o is high only while the sequencer is idle.
// Reset empties every queue at once; the link memory needs no clearing pass.
// A result stalled on m_axis holds the sequencer in its result state.
module priority_process_queues_core #(
  parameter int unsigned MAX_ENTRIES = 32,
  parameter int unsigned NUM_QUEUES  = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // command[2:0], queue_id[5:3], entry_index[10:6], priority_req[18:11], zero pad
  input  logic [ppq_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // status[0], removed_entry[5:1], head_entry[10:6], queue_empty[11], zero pad
  output logic [ppq_pkg::M_TDATA_W-1:0]  m_axis_tdata_o
);

  localparam int unsigned IW  = $clog2(MAX_ENTRIES);
  localparam int unsigned LW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned PW  = ppq_pkg::PRIO_W;
  localparam int unsigned WW  = PW + LW;
  localparam int unsigned CW  = ppq_pkg::CMD_W;
  localparam int unsigned QW  = ppq_pkg::QID_W;
  localparam int unsigned EW  = ppq_pkg::ENT_W;
  localparam logic [LW-1:0] END_LINK = LW'(MAX_ENTRIES);

  ppq_pkg::state_e state_q, state_d;

  logic [CW-1:0] cmd_q;
  logic [QW-1:0] qid_q;
  logic [EW-1:0] ent_q;
  logic [PW-1:0] prio_q;

  logic [LW-1:0] first_q [NUM_QUEUES];
  logic [MAX_ENTRIES-1:0] queued_q;

  logic [LW-1:0] cur_q, cur_d;
  logic [LW-1:0] prev_q, prev_d;
  logic [LW-1:0] target_q, target_d;
  logic [LW-1:0] removed_q, removed_d;
  logic [PW-1:0] prev_prio_q, prev_prio_d;
  logic          fail_q, fail_d;

  // Link memory: priority over next link, one word per pool entry
  logic [WW-1:0] mem [MAX_ENTRIES];
  logic [WW-1:0] rdata_q;
  logic          mem_re;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;

  logic          first_we;
  logic [LW-1:0] first_wdata;
  logic          clr_en, set_en;
  logic [IW-1:0] clr_idx;

  logic          m_valid_q;
  logic [ppq_pkg::M_TDATA_W-1:0] m_data_q;
  logic          out_load;

  logic          s_acc;
  logic          q_ok, e_ok, cur_end;
  logic [QIW-1:0] qi;
  logic [IW-1:0] ei;
  logic [LW-1:0] e_lw;
  logic [LW-1:0] first_cur;
  logic [PW-1:0] rd_prio;
  logic [LW-1:0] rd_link;
  logic          head_end;
  logic [ppq_pkg::M_FIELDS_W-1:0] out_fields;

  assign s_axis_tready_o = (state_q == ppq_pkg::ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Decode the latched command word
  assign q_ok      = 32'(qid_q) < NUM_QUEUES;
  assign e_ok      = 32'(ent_q) < MAX_ENTRIES;
  assign qi        = QIW'(qid_q);
  assign ei        = IW'(ent_q);
  assign e_lw      = LW'(ent_q);
  assign first_cur = q_ok ? first_q[qi] : END_LINK;
  assign cur_end   = (cur_q == END_LINK);
  assign rd_prio   = rdata_q[WW-1 -: PW];
  assign rd_link   = rdata_q[LW-1:0];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    target_d    = target_q;
    removed_d   = removed_q;
    prev_prio_d = prev_prio_q;
    fail_d      = fail_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = IW'(prev_q);
    mem_wdata   = {prev_prio_q, e_lw};
    first_we    = 1'b0;
    first_wdata = END_LINK;
    clr_en      = 1'b0;
    clr_idx     = IW'(cur_q);
    set_en      = 1'b0;
    out_load    = 1'b0;

    unique case (state_q)
      ppq_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = ppq_pkg::ST_DISP;
        end
      end

      ppq_pkg::ST_DISP: begin
        prev_d    = END_LINK;
        fail_d    = ppq_pkg::STATUS_OK;
        removed_d = '0;
        cur_d     = first_cur;
        mem_re    = 1'b1;
        if (!q_ok) begin
          fail_d  = ppq_pkg::STATUS_FAIL;
          state_d = ppq_pkg::ST_DONE;
        end else begin
          unique case (cmd_q)
            ppq_pkg::CMD_CLEAR: begin
              state_d = ppq_pkg::ST_WALK;
            end
            ppq_pkg::CMD_INSERT: begin
              if (!e_ok || queued_q[ei]) begin
                fail_d  = ppq_pkg::STATUS_FAIL;
                state_d = ppq_pkg::ST_DONE;
              end else begin
                state_d = ppq_pkg::ST_WALK;
              end
            end
            ppq_pkg::CMD_POP: begin
              if (first_cur == END_LINK) begin
                fail_d  = ppq_pkg::STATUS_FAIL;
                state_d = ppq_pkg::ST_DONE;
              end else begin
                target_d = first_cur;
                state_d  = ppq_pkg::ST_WALK;
              end
            end
            ppq_pkg::CMD_REMOVE: begin
              // An entry that sits in no queue cannot be found
              if (!e_ok || !queued_q[ei]) begin
                fail_d  = ppq_pkg::STATUS_FAIL;
                state_d = ppq_pkg::ST_DONE;
              end else begin
                target_d = e_lw;
                state_d  = ppq_pkg::ST_WALK;
              end
            end
            default: begin
              fail_d  = (first_cur == END_LINK);
              state_d = ppq_pkg::ST_DONE;
            end
          endcase
        end
      end

      ppq_pkg::ST_WALK: begin
        unique case (cmd_q)
          ppq_pkg::CMD_CLEAR: begin
            // Release each entry, then mark the queue empty
            if (cur_end) begin
              first_we    = 1'b1;
              first_wdata = END_LINK;
              state_d     = ppq_pkg::ST_DONE;
            end else begin
              clr_en = 1'b1;
              cur_d  = rd_link;
              mem_re = 1'b1;
            end
          end
          ppq_pkg::CMD_INSERT: begin
            // Stop at the first entry of lower priority
            if (cur_end || (rd_prio < prio_q)) begin
              mem_we    = 1'b1;
              mem_waddr = ei;
              mem_wdata = {prio_q, cur_q};
              set_en    = 1'b1;
              if (prev_q != END_LINK) begin
                state_d = ppq_pkg::ST_FIX;
              end else begin
                first_we    = 1'b1;
                first_wdata = e_lw;
                state_d     = ppq_pkg::ST_DONE;
              end
            end else begin
              prev_d      = cur_q;
              prev_prio_d = rd_prio;
              cur_d       = rd_link;
              mem_re      = 1'b1;
            end
          end
          default: begin
            // Pop and remove: find the target and unlink it
            if (cur_end) begin
              fail_d  = ppq_pkg::STATUS_FAIL;
              state_d = ppq_pkg::ST_DONE;
            end else if (cur_q == target_q) begin
              clr_en    = 1'b1;
              removed_d = cur_q;
              if (prev_q != END_LINK) begin
                mem_we    = 1'b1;
                mem_waddr = IW'(prev_q);
                mem_wdata = {prev_prio_q, rd_link};
              end else begin
                first_we    = 1'b1;
                first_wdata = rd_link;
              end
              state_d = ppq_pkg::ST_DONE;
            end else begin
              prev_d      = cur_q;
              prev_prio_d = rd_prio;
              cur_d       = rd_link;
              mem_re      = 1'b1;
            end
          end
        endcase
      end

      ppq_pkg::ST_FIX: begin
        // Point the predecessor at the inserted entry
        mem_we    = 1'b1;
        mem_waddr = IW'(prev_q);
        mem_wdata = {prev_prio_q, e_lw};
        state_d   = ppq_pkg::ST_DONE;
      end

      ppq_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ppq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ppq_pkg::ST_IDLE;
      end
    endcase
  end

  // Assemble the result from the updated queue head
  assign head_end   = !q_ok || (first_q[qi] == END_LINK);
  assign out_fields = {head_end,
                       head_end ? EW'(0) : EW'(first_q[qi]),
                       EW'(removed_q),
                       fail_q};

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ppq_pkg::ST_IDLE;
      queued_q  <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        first_q[i] <= END_LINK;
      end
    end else begin
      state_q <= state_d;
      if (first_we) begin
        first_q[qi] <= first_wdata;
      end
      if (clr_en) begin
        queued_q[clr_idx] <= 1'b0;
      end
      if (set_en) begin
        queued_q[ei] <= 1'b1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and the latched command word
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      cmd_q  <= s_axis_tdata_i[CW-1:0];
      qid_q  <= s_axis_tdata_i[CW +: QW];
      ent_q  <= s_axis_tdata_i[CW+QW +: EW];
      prio_q <= s_axis_tdata_i[CW+QW+EW +: PW];
    end
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    target_q    <= target_d;
    removed_q   <= removed_d;
    prev_prio_q <= prev_prio_d;
    fail_q      <= fail_d;
    if (out_load) begin
      m_data_q <= {{ppq_pkg::M_PAD_W{1'b0}}, out_fields};
    end
  end

  // Link memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[IW'(cur_d)];
    end
  end

endmodule

### hw/rtl/ppq_checker.sv
`include "priority_process_queues_core_assert.svh"

module ppq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [ppq_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  logic s_acc;
  logic m_stall;
  logic status;
  logic empty;
  logic [ppq_pkg::ENT_W-1:0] removed;
  logic [ppq_pkg::ENT_W-1:0] head;

  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign m_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign status  = m_axis_tdata_o[ppq_pkg::OUT_STATUS];
  assign empty   = m_axis_tdata_o[ppq_pkg::OUT_EMPTY];
  assign removed = m_axis_tdata_o[ppq_pkg::OUT_REMOVED +: ppq_pkg::ENT_W];
  assign head    = m_axis_tdata_o[ppq_pkg::OUT_HEAD +: ppq_pkg::ENT_W];

  // A stalled result word holds
  `PPQ_ASSERT_NEXT(a_out_hold, m_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result word changed while stalled")

  // The unit is busy right after it takes a command word
  `PPQ_ASSERT_NEXT(a_busy_after_accept, s_acc, !s_axis_tready_o, "ready stayed high after accept")

  // An empty queue reports head zero
  `PPQ_ASSERT_NOW(a_empty_head, m_axis_tvalid_o && empty, head == '0, "empty queue with nonzero head")

  // A failed command removes nothing
  `PPQ_ASSERT_NOW(a_fail_removed, m_axis_tvalid_o && (status == ppq_pkg::STATUS_FAIL), removed == '0, "failed command reports a removed entry")

endmodule

bind priority_process_queues_core ppq_checker u_ppq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
